@@ sv/point_segment_distance_macros.svh @@
// Assertion macros shared by the point_segment_distance checker.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef POINT_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/psd_pkg.sv @@
// Package for the point to segment distance pipeline.
// Holds widths, region codes and beat payload types; no dependencies.
package psd_pkg;

    localparam int COORD_W    = 20;
    localparam int DIFF_W     = 21;
    localparam int PROD_W     = 42;
    localparam int DOT_W      = 43;
    localparam int LEN_W      = 42;
    localparam int DX_W       = 22;
    localparam int SQ_W       = 44;
    localparam int ROOT_W     = 45;
    localparam int ROOT_STEPS = 22;
    localparam int DIST_W     = 21;
    localparam int REGION_W   = 2;

    localparam int RATIO_FRAC_BITS_DEFAULT = 16;

    localparam logic [DIST_W-1:0]   DIST_MAX        = {DIST_W{1'b1}};
    localparam logic [REGION_W-1:0] REGION_START    = 2'd0;
    localparam logic [REGION_W-1:0] REGION_INTERIOR = 2'd1;
    localparam logic [REGION_W-1:0] REGION_END      = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } psd_query_t;

    typedef struct packed {
        logic [DIST_W-1:0]   distance;
        logic [REGION_W-1:0] nearest_region;
    } psd_result_t;

    // Values that ride along the divider chain untouched.
    typedef struct packed {
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] b;
        logic signed [DIFF_W-1:0] c;
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] pex;
        logic signed [DIFF_W-1:0] pey;
        logic [REGION_W-1:0]      region;
    } psd_side_t;

endpackage

@@ sv/psd_query_if.sv @@
// Query channel: one point and one segment per beat.
// Depends on psd_pkg for the payload type.
interface psd_query_if;
    logic                valid;
    logic                ready;
    psd_pkg::psd_query_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/psd_result_if.sv @@
// Result channel: distance and region code per beat.
// Depends on psd_pkg for the payload type.
interface psd_result_if;
    logic                 valid;
    logic                 ready;
    psd_pkg::psd_result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/psd_div_cell.sv @@
// One restoring division step of the projection ratio pipeline.
// Depends on psd_pkg for the side payload type and widths.
module psd_div_cell #(
    parameter int QW       = psd_pkg::RATIO_FRAC_BITS_DEFAULT + 1,
    parameter bit SHIFT_EN = 1'b1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        vld_in,
    input  psd_pkg::psd_side_t          side_in,
    input  logic [psd_pkg::LEN_W-1:0]   len_in,
    input  logic [psd_pkg::DOT_W-1:0]   rem_in,
    input  logic [QW-1:0]               quo_in,
    output logic                        vld_out,
    output psd_pkg::psd_side_t          side_out,
    output logic [psd_pkg::LEN_W-1:0]   len_out,
    output logic [psd_pkg::DOT_W-1:0]   rem_out,
    output logic [QW-1:0]               quo_out
);
    logic                        vld_reg;
    psd_pkg::psd_side_t          side_reg;
    logic [psd_pkg::LEN_W-1:0]   len_reg;
    logic [psd_pkg::DOT_W-1:0]   rem_reg, rem_next, rem_sh;
    logic [QW-1:0]               quo_reg, quo_next;
    logic                        ge;

    // The remainder stays below the divisor, so the shift never loses a bit.
    assign rem_sh   = SHIFT_EN ? {rem_in[psd_pkg::DOT_W-2:0], 1'b0} : rem_in;
    assign ge       = rem_sh >= {1'b0, len_in};
    assign rem_next = ge ? rem_sh - {1'b0, len_in} : rem_sh;
    assign quo_next = {quo_in[QW-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_in;
            len_reg  <= len_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign vld_out  = vld_reg;
    assign side_out = side_reg;
    assign len_out  = len_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
endmodule

@@ sv/psd_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
// Depends on psd_pkg for widths.
module psd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         vld_in,
    input  logic [psd_pkg::REGION_W-1:0] region_in,
    input  logic [psd_pkg::ROOT_W-1:0]   op_in,
    input  logic [psd_pkg::ROOT_W-1:0]   res_in,
    output logic                         vld_out,
    output logic [psd_pkg::REGION_W-1:0] region_out,
    output logic [psd_pkg::ROOT_W-1:0]   op_out,
    output logic [psd_pkg::ROOT_W-1:0]   res_out
);
    localparam logic [psd_pkg::ROOT_W-1:0] ONE = psd_pkg::ROOT_W'(1) << (2 * STEP);

    logic                         vld_reg;
    logic [psd_pkg::REGION_W-1:0] region_reg;
    logic [psd_pkg::ROOT_W-1:0]   op_reg, res_reg, op_next, res_next, trial;
    logic                         ge;

    assign trial    = res_in + ONE;
    assign ge       = op_in >= trial;
    assign op_next  = ge ? op_in - trial : op_in;
    assign res_next = ge ? (res_in >> 1) + ONE : res_in >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            region_reg <= region_in;
            op_reg     <= op_next;
            res_reg    <= res_next;
        end
    end

    assign vld_out    = vld_reg;
    assign region_out = region_reg;
    assign op_out     = op_reg;
    assign res_out    = res_reg;
endmodule

@@ sv/point_segment_distance.sv @@
// Each query beat passes every stage in order, from the differences to the output register.
// Throughput: one query per cycle; the pipeline is a row of single-step cells.
// Every stage advances together and holds only while a result waits unaccepted.
// The divider needs RATIO_FRAC_BITS + 1 cells and the square root 22 cells.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data registers keep no reset.
// Depends on psd_pkg, psd_query_if, psd_result_if, psd_div_cell and psd_sqrt_cell.
module point_segment_distance #(
    parameter int RATIO_FRAC_BITS = psd_pkg::RATIO_FRAC_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    psd_query_if.sink           query,
    psd_result_if.source        result
);
    localparam int QW   = RATIO_FRAC_BITS + 1;
    localparam int TC_W = QW + 1 + psd_pkg::DIFF_W;
    localparam int NDIV = RATIO_FRAC_BITS + 1;

    localparam logic signed [TC_W-1:0] HALF = TC_W'(1) << (RATIO_FRAC_BITS - 1);
    localparam logic [QW:0]            T_ONE = (QW + 1)'(1) << RATIO_FRAC_BITS;

    logic adv;

    // Stage 0: differences.
    logic                               s0_vld_reg;
    psd_pkg::psd_side_t                 s0_side_reg;
    // Stage 1: products.
    logic                               s1_vld_reg;
    psd_pkg::psd_side_t                 s1_side_reg;
    logic signed [psd_pkg::PROD_W-1:0]  ac_reg, bd_reg, cc_reg, dd_reg;
    // Stage 2: dot, length and region.
    logic                               s2_vld_reg;
    psd_pkg::psd_side_t                 s2_side_reg;
    logic [psd_pkg::LEN_W-1:0]          s2_len_reg;
    logic [psd_pkg::DOT_W-1:0]          s2_rem_reg;
    logic signed [psd_pkg::DOT_W-1:0]   dot;
    logic [psd_pkg::LEN_W-1:0]          len;
    logic [psd_pkg::REGION_W-1:0]       region_next;
    psd_pkg::psd_side_t                 s2_side_next;

    // Divider chain.
    logic                               dv_vld  [0:NDIV];
    psd_pkg::psd_side_t                 dv_side [0:NDIV];
    logic [psd_pkg::LEN_W-1:0]          dv_len  [0:NDIV];
    logic [psd_pkg::DOT_W-1:0]          dv_rem  [0:NDIV];
    logic [QW-1:0]                      dv_quo  [0:NDIV];

    // Ratio rounding stage.
    logic                               rt_vld_reg;
    psd_pkg::psd_side_t                 rt_side_reg;
    logic [QW-1:0]                      t_reg;
    logic [psd_pkg::DOT_W-1:0]          rem_left;
    logic                               bump;
    logic [QW:0]                        q_inc;
    logic [QW-1:0]                      t_next;

    // Offset product stage.
    logic                               mp_vld_reg;
    psd_pkg::psd_side_t                 mp_side_reg;
    logic signed [TC_W-1:0]             tc_x_reg, tc_y_reg;

    // Delta stage.
    logic                               dl_vld_reg;
    logic [psd_pkg::REGION_W-1:0]       dl_region_reg;
    logic signed [psd_pkg::DX_W-1:0]    dx_reg, dy_reg, dx_next, dy_next;
    logic signed [TC_W-1:0]             off_x_full, off_y_full;
    logic signed [psd_pkg::DX_W-1:0]    off_x, off_y;

    // Square and sum stages.
    logic                               sq_vld_reg;
    logic [psd_pkg::REGION_W-1:0]       sq_region_reg;
    logic signed [psd_pkg::SQ_W-1:0]    sqx_reg, sqy_reg;
    logic                               sm_vld_reg;
    logic [psd_pkg::REGION_W-1:0]       sm_region_reg;
    logic [psd_pkg::ROOT_W-1:0]         sum_reg;

    // Square root chain.
    logic                               rq_vld    [0:psd_pkg::ROOT_STEPS];
    logic [psd_pkg::REGION_W-1:0]       rq_region [0:psd_pkg::ROOT_STEPS];
    logic [psd_pkg::ROOT_W-1:0]         rq_op     [0:psd_pkg::ROOT_STEPS];
    logic [psd_pkg::ROOT_W-1:0]         rq_res    [0:psd_pkg::ROOT_STEPS];

    // Output register.
    logic                               out_vld_reg;
    psd_pkg::psd_result_t               out_reg;
    logic [psd_pkg::ROOT_W-1:0]         root_rnd;

    function automatic logic signed [psd_pkg::DIFF_W-1:0] DIFF_EXT(
        input logic signed [psd_pkg::COORD_W-1:0] v
    );
        DIFF_EXT = {v[psd_pkg::COORD_W-1], v};
    endfunction

    assign adv         = !out_vld_reg || result.ready;
    assign query.ready = adv;

    // ---------------- stage 0 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            rt_vld_reg  <= 1'b0;
            mp_vld_reg  <= 1'b0;
            dl_vld_reg  <= 1'b0;
            sq_vld_reg  <= 1'b0;
            sm_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg  <= query.valid;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            rt_vld_reg  <= dv_vld[NDIV];
            mp_vld_reg  <= rt_vld_reg;
            dl_vld_reg  <= mp_vld_reg;
            sq_vld_reg  <= dl_vld_reg;
            sm_vld_reg  <= sq_vld_reg;
            out_vld_reg <= rq_vld[psd_pkg::ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_side_reg.a   <= DIFF_EXT(query.data.point_x) - DIFF_EXT(query.data.start_x);
            s0_side_reg.b   <= DIFF_EXT(query.data.point_y) - DIFF_EXT(query.data.start_y);
            s0_side_reg.c   <= DIFF_EXT(query.data.end_x) - DIFF_EXT(query.data.start_x);
            s0_side_reg.d   <= DIFF_EXT(query.data.end_y) - DIFF_EXT(query.data.start_y);
            s0_side_reg.pex <= DIFF_EXT(query.data.point_x) - DIFF_EXT(query.data.end_x);
            s0_side_reg.pey <= DIFF_EXT(query.data.point_y) - DIFF_EXT(query.data.end_y);
            s0_side_reg.region <= psd_pkg::REGION_START;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg <= s0_side_reg;
            ac_reg      <= s0_side_reg.a * s0_side_reg.c;
            bd_reg      <= s0_side_reg.b * s0_side_reg.d;
            cc_reg      <= s0_side_reg.c * s0_side_reg.c;
            dd_reg      <= s0_side_reg.d * s0_side_reg.d;
        end
    end

    // ---------------- stage 2 ----------------
    assign dot = {ac_reg[psd_pkg::PROD_W-1], ac_reg} + {bd_reg[psd_pkg::PROD_W-1], bd_reg};
    // Each square is at most 2^40, so the sum fits without sign.
    assign len = {1'b0, cc_reg[psd_pkg::PROD_W-2:0]} + {1'b0, dd_reg[psd_pkg::PROD_W-2:0]};

    always_comb
    begin
        if (len == '0 || dot < 0)
        begin
            region_next = psd_pkg::REGION_START;
        end
        else if (dot > $signed({1'b0, len}))
        begin
            region_next = psd_pkg::REGION_END;
        end
        else
        begin
            region_next = psd_pkg::REGION_INTERIOR;
        end
        s2_side_next        = s1_side_reg;
        s2_side_next.region = region_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s2_side_next;
            s2_len_reg  <= len;
            s2_rem_reg  <= (region_next == psd_pkg::REGION_INTERIOR) ?
                           {1'b0, dot[psd_pkg::DOT_W-2:0]} : '0;
        end
    end

    // ---------------- divider chain ----------------
    assign dv_vld[0]  = s2_vld_reg;
    assign dv_side[0] = s2_side_reg;
    assign dv_len[0]  = s2_len_reg;
    assign dv_rem[0]  = s2_rem_reg;
    assign dv_quo[0]  = '0;

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        psd_div_cell #(
            .QW       (QW),
            .SHIFT_EN (i != 0)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .vld_in   (dv_vld[i]),
            .side_in  (dv_side[i]),
            .len_in   (dv_len[i]),
            .rem_in   (dv_rem[i]),
            .quo_in   (dv_quo[i]),
            .vld_out  (dv_vld[i+1]),
            .side_out (dv_side[i+1]),
            .len_out  (dv_len[i+1]),
            .rem_out  (dv_rem[i+1]),
            .quo_out  (dv_quo[i+1])
        );
    end

    // ---------------- ratio rounding ----------------
    // Round to nearest, halves up: bump when the remainder is at least half the divisor.
    assign rem_left = {1'b0, dv_len[NDIV]} - dv_rem[NDIV];
    assign bump     = dv_rem[NDIV] >= rem_left;
    assign q_inc    = {1'b0, dv_quo[NDIV]} + (QW + 1)'(bump);
    assign t_next   = (q_inc > T_ONE) ? T_ONE[QW-1:0] : q_inc[QW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt_side_reg <= dv_side[NDIV];
            t_reg       <= t_next;
        end
    end

    // ---------------- offset products ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mp_side_reg <= rt_side_reg;
            tc_x_reg    <= TC_W'($signed({1'b0, t_reg})) * TC_W'(rt_side_reg.c);
            tc_y_reg    <= TC_W'($signed({1'b0, t_reg})) * TC_W'(rt_side_reg.d);
        end
    end

    // ---------------- deltas ----------------
    assign off_x_full = (tc_x_reg + HALF) >>> RATIO_FRAC_BITS;
    assign off_y_full = (tc_y_reg + HALF) >>> RATIO_FRAC_BITS;
    assign off_x      = off_x_full[psd_pkg::DX_W-1:0];
    assign off_y      = off_y_full[psd_pkg::DX_W-1:0];

    always_comb
    begin
        case (mp_side_reg.region)
            psd_pkg::REGION_INTERIOR:
            begin
                dx_next = {mp_side_reg.a[psd_pkg::DIFF_W-1], mp_side_reg.a} - off_x;
                dy_next = {mp_side_reg.b[psd_pkg::DIFF_W-1], mp_side_reg.b} - off_y;
            end
            psd_pkg::REGION_END:
            begin
                dx_next = {mp_side_reg.pex[psd_pkg::DIFF_W-1], mp_side_reg.pex};
                dy_next = {mp_side_reg.pey[psd_pkg::DIFF_W-1], mp_side_reg.pey};
            end
            default:
            begin
                dx_next = {mp_side_reg.a[psd_pkg::DIFF_W-1], mp_side_reg.a};
                dy_next = {mp_side_reg.b[psd_pkg::DIFF_W-1], mp_side_reg.b};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl_region_reg <= mp_side_reg.region;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
        end
    end

    // ---------------- squares and sum ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_region_reg <= dl_region_reg;
            sqx_reg       <= dx_reg * dx_reg;
            sqy_reg       <= dy_reg * dy_reg;
            sm_region_reg <= sq_region_reg;
            sum_reg       <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        end
    end

    // ---------------- square root chain ----------------
    assign rq_vld[0]    = sm_vld_reg;
    assign rq_region[0] = sm_region_reg;
    assign rq_op[0]     = sum_reg;
    assign rq_res[0]    = '0;

    for (genvar j = 0; j < psd_pkg::ROOT_STEPS; j++)
    begin : g_sqrt
        psd_sqrt_cell #(
            .STEP (psd_pkg::ROOT_STEPS - 1 - j)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (adv),
            .vld_in     (rq_vld[j]),
            .region_in  (rq_region[j]),
            .op_in      (rq_op[j]),
            .res_in     (rq_res[j]),
            .vld_out    (rq_vld[j+1]),
            .region_out (rq_region[j+1]),
            .op_out     (rq_op[j+1]),
            .res_out    (rq_res[j+1])
        );
    end

    // ---------------- output ----------------
    assign root_rnd = rq_res[psd_pkg::ROOT_STEPS] +
        psd_pkg::ROOT_W'(rq_op[psd_pkg::ROOT_STEPS] > rq_res[psd_pkg::ROOT_STEPS]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.nearest_region <= rq_region[psd_pkg::ROOT_STEPS];
            out_reg.distance       <= (root_rnd > psd_pkg::ROOT_W'(psd_pkg::DIST_MAX)) ?
                                      psd_pkg::DIST_MAX : root_rnd[psd_pkg::DIST_W-1:0];
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;
endmodule

@@ sv/psd_checker.sv @@
// Port-level checker for point_segment_distance, attached by bind.
// Depends on psd_pkg and point_segment_distance_macros.svh.
`include "point_segment_distance_macros.svh"

module psd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         query_valid,
    input logic                         query_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [psd_pkg::REGION_W-1:0] result_region,
    input logic [psd_pkg::DIST_W-1:0]   result_distance
);
    // A waiting result stalls the whole pipeline, including the query side.
    `PSD_ASSERT_NOW(a_stall_blocks_query, result_valid && !result_ready, !query_ready, "query taken while result stalled")
    // With no result pending the block always takes a query.
    `PSD_ASSERT_NOW(a_idle_takes_query, !result_valid, query_ready, "query refused with empty output")
    // The region code is never the unused fourth code.
    `PSD_ASSERT_NOW(a_region_legal, result_valid, result_region == psd_pkg::REGION_START || result_region == psd_pkg::REGION_INTERIOR || result_region == psd_pkg::REGION_END, "illegal region code")
    // A stalled result beat holds its distance.
    `PSD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_distance), "stalled result changed")
endmodule

bind point_segment_distance psd_checker u_psd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .query_valid     (query.valid),
    .query_ready     (query.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_region   (result.data.nearest_region),
    .result_distance (result.data.distance)
);

@@ test/point_segment_distance_tb.sv @@
// Self-checking testbench for the point_segment_distance pipeline.
// Depends on psd_pkg, psd_query_if, psd_result_if and the block itself.
`timescale 1ns / 100ps

module point_segment_distance_tb;

    localparam int RATIO_BITS = 16;
    localparam longint RATIO_ONE = 64'sd1 << RATIO_BITS;

    typedef struct {
        psd_pkg::psd_query_t  qy;
        bit                   typed;
        psd_pkg::psd_result_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;

    psd_query_if  query ();
    psd_result_if result ();

    point_segment_distance dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .result (result.source)
    );

    psd_pkg::psd_result_t dist_expect_q[$];
    dir_row_t             dir_rows[$];
    int                   mismatch_cnt;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    bit                   recv_hold;
    bit                   typed_next;
    psd_pkg::psd_result_t typed_res;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Distance to the nearest point of the segment, with its region code.
    function automatic psd_pkg::psd_result_t nearest_distance(psd_pkg::psd_query_t qy);
        longint a, b, c, d, dot, len, dx, dy, t;
        longint unsigned rem, q, op, res, one;
        psd_pkg::psd_result_t r;
        int i;
        a = longint'(qy.point_x) - longint'(qy.start_x);
        b = longint'(qy.point_y) - longint'(qy.start_y);
        c = longint'(qy.end_x) - longint'(qy.start_x);
        d = longint'(qy.end_y) - longint'(qy.start_y);
        dot = a * c + b * d;
        len = c * c + d * d;
        if (len == 0 || dot < 0)
        begin
            r.nearest_region = psd_pkg::REGION_START;
            dx = a;
            dy = b;
        end
        else if (dot > len)
        begin
            r.nearest_region = psd_pkg::REGION_END;
            dx = longint'(qy.point_x) - longint'(qy.end_x);
            dy = longint'(qy.point_y) - longint'(qy.end_y);
        end
        else
        begin
            r.nearest_region = psd_pkg::REGION_INTERIOR;
            q = 0;
            rem = dot;
            if (rem >= len)
            begin
                q = 1;
                rem = rem - len;
            end
            for (i = 0; i < RATIO_BITS; i++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= len)
                begin
                    rem = rem - len;
                    q = q | 1;
                end
            end
            if (rem >= len - rem)
                q = q + 1;
            if (q > RATIO_ONE)
                q = RATIO_ONE;
            t = q;
            // Offsets round half toward +infinity; >>> floors.
            dx = a - ((t * c + (RATIO_ONE >>> 1)) >>> RATIO_BITS);
            dy = b - ((t * d + (RATIO_ONE >>> 1)) >>> RATIO_BITS);
        end
        op = dx * dx + dy * dy;
        res = 0;
        one = 64'd1 << 62;
        while (one > op)
            one = one >> 2;
        while (one != 0)
        begin
            if (op >= res + one)
            begin
                op = op - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        if (op > res)
            res = res + 1;
        if (res > psd_pkg::DIST_MAX)
            res = psd_pkg::DIST_MAX;
        r.distance = res[psd_pkg::DIST_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    function automatic void add_row(int px, int py, int sx, int sy, int ex, int ey,
                                    bit typed, int want_dist,
                                    logic [psd_pkg::REGION_W-1:0] region);
        dir_row_t row;
        row.qy.point_x = psd_pkg::COORD_W'(px);
        row.qy.point_y = psd_pkg::COORD_W'(py);
        row.qy.start_x = psd_pkg::COORD_W'(sx);
        row.qy.start_y = psd_pkg::COORD_W'(sy);
        row.qy.end_x   = psd_pkg::COORD_W'(ex);
        row.qy.end_y   = psd_pkg::COORD_W'(ey);
        row.typed = typed;
        row.res.distance = psd_pkg::DIST_W'(want_dist);
        row.res.nearest_region = region;
        dir_rows.push_back(row);
    endfunction

    function automatic logic signed [psd_pkg::COORD_W-1:0] small_coord();
        return psd_pkg::COORD_W'(int'($urandom_range(2047)) - 1024);
    endfunction

    function automatic psd_pkg::psd_query_t random_query();
        psd_pkg::psd_query_t qy;
        logic [127:0] raw;
        int mode;
        mode = $urandom_range(9);
        raw = {$urandom, $urandom, $urandom, $urandom};
        qy = raw[$bits(psd_pkg::psd_query_t)-1:0];
        if (mode >= 5 && mode <= 6)
        begin
            qy.point_x = small_coord();
            qy.point_y = small_coord();
            qy.start_x = small_coord();
            qy.start_y = small_coord();
            qy.end_x   = small_coord();
            qy.end_y   = small_coord();
        end
        else if (mode == 7)
        begin
            qy.end_x = qy.start_x;
            qy.end_y = qy.start_y;
        end
        else if (mode == 8)
        begin
            qy.point_x = $urandom_range(1) ? qy.start_x : qy.end_x;
            qy.point_y = $urandom_range(1) ? qy.start_y : qy.end_y;
        end
        else if (mode == 9)
        begin
            // Axis-aligned segment; ties in the rounding show up here.
            qy.end_y   = qy.start_y;
            qy.point_x = qy.start_x + small_coord();
        end
        return qy;
    endfunction

    // Offers one beat, with random idle cycles ahead of it.
    task automatic send_query(psd_pkg::psd_query_t qy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            query.valid <= 1'b0;
            @(negedge clk);
        end
        query.valid <= 1'b1;
        query.data  <= qy;
        do
            @(posedge clk);
        while (!query.ready);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && query.valid && query.ready)
        begin
            if (typed_next)
                dist_expect_q.push_back(typed_res);
            else
                dist_expect_q.push_back(nearest_distance(query.data));
        end
    end

    always @(posedge clk)
    begin
        psd_pkg::psd_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (dist_expect_q.size() == 0)
                flag_mismatch("unexpected result beat", result.data.distance, -1);
            else
            begin
                want = dist_expect_q.pop_front();
                if (result.data.distance !== want.distance)
                    flag_mismatch("distance", result.data.distance, want.distance);
                if (result.data.nearest_region !== want.nearest_region)
                    flag_mismatch("nearest_region", result.data.nearest_region,
                                  want.nearest_region);
            end
        end
    end

    always @(negedge clk)
    begin
        result.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #5_000_000;
        $display("point_segment_distance: mismatch");
        $finish;
    end

    initial
    begin
        int phase, n;
        mismatch_cnt = 0;
        recv_hold = 1'b0;
        typed_next = 1'b0;
        typed_res = '0;
        send_idle_pct = 34;
        recv_idle_pct = 51;
        rst_n = 1'b0;
        query.valid = 1'b0;
        query.data = '0;
        result.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(0, 0, 0, 0, 0, 0, 1, 0, psd_pkg::REGION_START);
        add_row(256, 0, 0, 0, 0, 0, 1, 256, psd_pkg::REGION_START);
        add_row(-256, 0, 0, 0, 256, 0, 1, 256, psd_pkg::REGION_START);
        add_row(512, 0, 0, 0, 256, 0, 1, 256, psd_pkg::REGION_END);
        add_row(128, 256, 0, 0, 256, 0, 1, 256, psd_pkg::REGION_INTERIOR);
        add_row(0, 256, 0, 0, 256, 0, 1, 256, psd_pkg::REGION_INTERIOR);
        add_row(256, 256, 0, 0, 256, 0, 1, 256, psd_pkg::REGION_INTERIOR);
        add_row(524287, 524287, 524287, 524287, 524287, 524287, 1, 0,
                psd_pkg::REGION_START);
        add_row(-524288, -524288, -524288, -524288, -524288, -524288, 1, 0,
                psd_pkg::REGION_START);
        add_row(524287, 524287, -524288, -524288, -524288, -524288, 0, 0,
                psd_pkg::REGION_START);
        add_row(-524288, 524287, 524287, -524288, 524287, -524288, 0, 0,
                psd_pkg::REGION_START);
        add_row(524287, 524287, -524288, -524288, 524287, -524288, 0, 0,
                psd_pkg::REGION_START);
        add_row(-524288, 524287, -524288, -524288, 524287, 524287, 0, 0,
                psd_pkg::REGION_START);
        add_row(524287, -524288, -524288, 524287, 524287, -524288, 0, 0,
                psd_pkg::REGION_START);
        add_row(-524288, -524288, 524287, 524287, -524288, 524287, 0, 0,
                psd_pkg::REGION_START);
        add_row(1, 1, 0, 0, 3, 0, 0, 0, psd_pkg::REGION_START);
        add_row(2, 5, -1, -1, 1, 1, 0, 0, psd_pkg::REGION_START);
        add_row(-1, 1, 1, -1, -1, -1, 0, 0, psd_pkg::REGION_START);

        foreach (dir_rows[i])
        begin
            typed_next <= dir_rows[i].typed;
            typed_res  <= dir_rows[i].res;
            send_query(dir_rows[i].qy);
        end
        typed_next <= 1'b0;

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 34 : 0;
            if (phase == 0)
            begin
                // Long receiver stall so the pipeline fills and backs up.
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (300) @(negedge clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (n = 0; n < 520; n++)
            begin
                if (phase == 1 && n == 260)
                begin
                    query.valid <= 1'b0;
                    @(negedge clk);
                    while (dist_expect_q.size() != 0)
                        @(negedge clk);
                end
                send_query(random_query());
            end
        end
        query.valid <= 1'b0;

        while (dist_expect_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (mismatch_cnt == 0 && dist_expect_q.size() == 0)
            $display("point_segment_distance: match");
        else
            $display("point_segment_distance: mismatch");
        $finish;
    end
endmodule
